>>> rtl/core/cbs_pkg.sv
package cbs_pkg;

  // geometry
  localparam int unsigned CellCount = 5;
  localparam int unsigned AdcW      = 14;
  localparam int unsigned TempW     = 8;
  localparam int unsigned GainW     = 9;
  localparam int unsigned OffsW     = 8;
  localparam int unsigned ThrW      = 13;
  localparam int unsigned MvW       = 16;
  localparam int unsigned MinW      = 13;
  localparam int unsigned MaskW     = 5;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 13;
  localparam int unsigned InDataW   = 24;
  localparam int unsigned OutDataW  = 24;

  // divide by 1000 as multiply by ceil(2^33/1000) then shift; exact below 2^24
  localparam int unsigned ProdW      = AdcW + GainW;
  localparam int unsigned RecipW     = 24;
  localparam int unsigned RecipShift = 33;
  localparam int unsigned ScaledW    = ProdW + RecipW;
  localparam int unsigned QuotW      = 14;
  localparam logic [RecipW-1:0] RecipK1000 = 24'd8589935;

  // reset values
  localparam logic [MinW-1:0]  MinStartMv  = 13'd5000;
  localparam logic [GainW-1:0] GainRst     = 9'd380;
  localparam logic [OffsW-1:0] OffsRst     = 8'sd0;
  localparam logic [TempW-1:0] TminRst     = 8'sd0;
  localparam logic [TempW-1:0] TmaxRst     = 8'sd45;
  localparam logic [ThrW-1:0]  DiffRst     = 13'd15;
  localparam logic [ThrW-1:0]  StartRst    = 13'd3600;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ADC_GAIN  = 3'd0,
    CFG_ADC_OFFS  = 3'd1,
    CFG_TEMP_MIN  = 3'd2,
    CFG_TEMP_MAX  = 3'd3,
    CFG_DIFF_MV   = 3'd4,
    CFG_START_MV  = 3'd5
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_CONV,
    ST_SWEEP,
    ST_DONE
  } state_e;

endpackage

>>> rtl/core/cbs_ram.sv
module cbs_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 5
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // one write port, registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/cell_balance_selector_unit.sv
// datapath: an item passes the product register and the reciprocal multiply register, then is converted and stored
// handshake: no new item is taken while one is in the product stage; the next can be taken as the previous is stored
// batch end: the last item is followed by a sweep over the
//   cell store (one read per cycle), then the result register is loaded once the output is free
// reset: asynchronous, active low; config registers return to defaults, minimum to 5000 mV
// and the cell counter to zero; the cell store is not cleared
module cell_balance_selector_unit import cbs_pkg::*; #(
  parameter int unsigned CELL_COUNT = CellCount
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // slave stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // [13:0] adc_code, [21:14] temperature_c
  // master stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // [4:0] balance_mask, [17:5] min_cell_mv
  // configuration writes
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned IdxW     = $clog2(CELL_COUNT);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(CELL_COUNT - 1);
  localparam int unsigned MaskBits = (CELL_COUNT < MaskW) ? CELL_COUNT : MaskW;

  state_e state_q, state_d;

  logic [GainW-1:0] gain_q;
  logic [OffsW-1:0] offs_q;
  logic [TempW-1:0] tmin_q, tmax_q;
  logic [ThrW-1:0]  diff_q, start_q;

  logic [ProdW-1:0]   prod_q;
  logic [ScaledW-1:0] scaled_q;
  logic [TempW-1:0]   temp_q;
  logic [IdxW-1:0]    cnt_q, cnt_d;
  logic [MinW-1:0]    min_q, min_d;

  logic [IdxW-1:0]  iss_q, iss_d;
  logic [IdxW-1:0]  rd_idx_q;
  logic             rd_vld_q;
  logic             prev_cand_q, prev_cand_d;
  logic [MvW-1:0]   prev_v_q;
  logic [MaskW-1:0] mask_q, mask_d;

  logic             out_vld_q, out_vld_d;
  logic [MaskW-1:0] out_mask_q;
  logic [MinW-1:0]  out_min_q;

  logic             in_acc, cfg_acc;
  logic             ram_we;
  logic [MvW-1:0]   ram_rdata;
  logic             is_last_cell;
  logic             out_load;

  assign in_acc  = s_axis_tvalid & s_axis_tready;
  assign cfg_ready_o = 1'b1;
  assign cfg_acc = cfg_valid_i;
  assign is_last_cell = (cnt_q == LastIdx);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q  <= GainRst;
      offs_q  <= OffsRst;
      tmin_q  <= TminRst;
      tmax_q  <= TmaxRst;
      diff_q  <= DiffRst;
      start_q <= StartRst;
    end else if (cfg_acc) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_ADC_GAIN: gain_q  <= cfg_data_i[GainW-1:0];
        CFG_ADC_OFFS: offs_q  <= cfg_data_i[OffsW-1:0];
        CFG_TEMP_MIN: tmin_q  <= cfg_data_i[TempW-1:0];
        CFG_TEMP_MAX: tmax_q  <= cfg_data_i[TempW-1:0];
        CFG_DIFF_MV:  diff_q  <= cfg_data_i[ThrW-1:0];
        CFG_START_MV: start_q <= cfg_data_i[ThrW-1:0];
        default: ;
      endcase
    end
  end

  // conversion datapath: raw product, reciprocal product
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      prod_q <= ProdW'(s_axis_tdata[AdcW-1:0]) * ProdW'(gain_q);
      temp_q <= s_axis_tdata[AdcW +: TempW];
    end
    scaled_q <= ScaledW'(prod_q) * ScaledW'(RecipK1000);
  end

  // quotient plus offset, negative results clamp to zero
  logic [QuotW-1:0]        quot;
  logic signed [QuotW:0]   mv_sum;
  logic [MvW-1:0]          mv;
  assign quot   = scaled_q[RecipShift +: QuotW];
  assign mv_sum = $signed({1'b0, quot}) +
                  $signed({{(QuotW + 1 - OffsW){offs_q[OffsW-1]}}, offs_q});
  assign mv     = mv_sum[QuotW] ? '0 : {{(MvW - QuotW){1'b0}}, mv_sum[QuotW-1:0]};

  cbs_ram #(
    .Width (MvW),
    .Depth (CELL_COUNT)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cnt_q),
    .wdata_i (mv),
    .raddr_i (iss_q),
    .rdata_o (ram_rdata)
  );

  // sweep: candidate test and pair thinning, one cell per cycle
  logic           temp_ok;
  logic           proc;
  logic           cand;
  logic           bit_a;
  logic [IdxW-1:0] idx_a;

  assign temp_ok = ($signed(temp_q) >= $signed(tmin_q)) && ($signed(temp_q) <= $signed(tmax_q));
  assign proc    = rd_vld_q && (state_q == ST_SWEEP);
  assign idx_a   = rd_idx_q - 1'b1;
  assign cand    = temp_ok &&
                   ((ram_rdata - {{(MvW - MinW){1'b0}}, min_q}) >= {{(MvW - ThrW){1'b0}}, diff_q}) &&
                   (ram_rdata >= {{(MvW - ThrW){1'b0}}, start_q});

  always_comb begin
    bit_a       = prev_cand_q;
    prev_cand_d = cand;
    if (rd_idx_q != '0 && prev_cand_q && cand) begin
      if (prev_v_q < ram_rdata) begin
        bit_a       = 1'b0;
        prev_cand_d = 1'b1;
      end else begin
        bit_a       = 1'b1;
        prev_cand_d = 1'b0;
      end
    end
  end

  always_comb begin
    mask_d = mask_q;
    // mask bits beyond the cell count stay clear
    if (state_q == ST_CONV && is_last_cell) begin
      mask_d = '0;
    end
    for (int j = 0; j < MaskBits; j++) begin
      if (proc && rd_idx_q != '0 && idx_a == IdxW'(j)) begin
        mask_d[j] = bit_a;
      end
      if (proc && rd_idx_q == LastIdx && rd_idx_q == IdxW'(j)) begin
        mask_d[j] = prev_cand_d;
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_acc) state_d = ST_MUL;
      ST_MUL:   state_d = ST_CONV;
      ST_CONV: begin
        if (is_last_cell)  state_d = ST_SWEEP;
        else if (in_acc)   state_d = ST_MUL;
        else               state_d = ST_IDLE;
      end
      ST_SWEEP: if (proc && rd_idx_q == LastIdx) state_d = ST_DONE;
      ST_DONE:  if (out_load) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    s_axis_tready = 1'b0;
    ram_we        = 1'b0;
    out_load      = 1'b0;
    case (state_q)
      ST_IDLE:  s_axis_tready = 1'b1;
      ST_CONV: begin
        ram_we        = 1'b1;
        s_axis_tready = !is_last_cell;
      end
      ST_DONE:  out_load = !out_vld_q || m_axis_tready;
      default: ;
    endcase
  end

  // counter, minimum and sweep index
  always_comb begin
    cnt_d = cnt_q;
    min_d = min_q;
    if (ram_we) begin
      cnt_d = is_last_cell ? '0 : cnt_q + 1'b1;
      if (mv < {{(MvW - MinW){1'b0}}, min_q}) begin
        min_d = mv[MinW-1:0];
      end
    end
    if (out_load) begin
      min_d = MinStartMv;
    end
    iss_d = '0;
    if (state_q == ST_SWEEP) begin
      iss_d = (iss_q == LastIdx) ? iss_q : iss_q + 1'b1;
    end
  end

  // output register
  always_comb begin
    out_vld_d = out_vld_q;
    if (out_load)           out_vld_d = 1'b1;
    else if (m_axis_tready) out_vld_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      min_q     <= MinStartMv;
      iss_q     <= '0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      min_q     <= min_d;
      iss_q     <= iss_d;
      rd_vld_q  <= (state_q == ST_SWEEP);
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= iss_q;
    mask_q   <= mask_d;
    if (proc) begin
      prev_cand_q <= prev_cand_d;
      prev_v_q    <= ram_rdata;
    end
    if (out_load) begin
      out_mask_q <= mask_q;
      out_min_q  <= min_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(OutDataW - MaskW - MinW){1'b0}}, out_min_q, out_mask_q};

  // checks
  a_min_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    min_q <= MinStartMv)
    else $error("running minimum above start value");

  a_sweep_from_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(state_q == ST_SWEEP) |-> (cnt_q == '0 && iss_q == '0))
    else $error("sweep started with counter not cleared");

  a_sweep_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && rd_idx_q == LastIdx) |=> state_q == ST_DONE)
    else $error("sweep did not finish after last cell");

  a_out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !m_axis_tready) |=> (out_vld_q && $stable(out_mask_q) && $stable(out_min_q)))
    else $error("result dropped before transaction");

  a_no_write_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SWEEP) |-> !in_acc)
    else $error("item taken during sweep");

endmodule
